>>> sv/cpt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cpt_pkg: shared types and constants of the call profile tracker
// Sizes of the entry table and call stack, command and status codes,
// and the per-entry statistics record.
// ----------------------------------------------------------------------------
package cpt_pkg;

  localparam int NUM_ENTRIES = 64;
  localparam int STACK_SLOTS = 128;

  localparam int ID_W    = 6;
  localparam int TS_W    = 48;
  localparam int ACC_W   = 64;
  localparam int DEPTH_OUT_W = 8;

  localparam int ENT_AW     = $clog2(NUM_ENTRIES);
  localparam int USED_W     = $clog2(NUM_ENTRIES + 1);
  localparam int PAIR_DEPTH = NUM_ENTRIES * NUM_ENTRIES;
  localparam int PAIR_AW    = $clog2(PAIR_DEPTH);
  localparam int STK_AW     = $clog2(STACK_SLOTS);
  localparam int DEPTH_W    = $clog2(STACK_SLOTS + 1);

  typedef enum logic [2:0] {
    CMD_REGISTER = 3'd0,
    CMD_ENTER    = 3'd1,
    CMD_LEAVE    = 3'd2,
    CMD_TICK     = 3'd3,
    CMD_READ     = 3'd4
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_FULL    = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_CLR,
    S_IDLE,
    S_STK,
    S_RD,
    S_WR
  } state_t;

  typedef struct packed {
    logic [ACC_W-1:0] calls;
    logic [ACC_W-1:0] wall;
    logic [ACC_W-1:0] self_t;
    logic [ACC_W-1:0] user;
    logic [ACC_W-1:0] sys;
    logic [ACC_W-1:0] wait_t;
    logic             active;
    logic [TS_W-1:0]  start_wall;
    logic [TS_W-1:0]  start_user;
    logic [TS_W-1:0]  start_sys;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage
`default_nettype wire

>>> sv/cpt_evt_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cpt_evt_if: trace event channel
// Valid/ready channel carrying one trace event per transfer.
// ----------------------------------------------------------------------------
interface cpt_evt_if
  import cpt_pkg::*;
  ;
  logic            valid;
  logic            ready;
  logic [2:0]      cmd;
  logic [ID_W-1:0] func_id;
  logic [ID_W-1:0] caller_sel;
  logic [TS_W-1:0] now_wall_us;
  logic [TS_W-1:0] now_user_us;
  logic [TS_W-1:0] now_sys_us;

  modport source (output valid, cmd, func_id, caller_sel, now_wall_us, now_user_us,
                  now_sys_us, input ready);
  modport sink (input valid, cmd, func_id, caller_sel, now_wall_us, now_user_us,
                now_sys_us, output ready);
endinterface
`default_nettype wire

>>> sv/cpt_res_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cpt_res_if: result channel
// Valid/ready channel carrying one result per transfer.
// ----------------------------------------------------------------------------
interface cpt_res_if
  import cpt_pkg::*;
  ;
  logic                   valid;
  logic                   ready;
  logic [1:0]             status;
  logic [ID_W-1:0]        assigned_id;
  logic [ACC_W-1:0]       calls;
  logic [ACC_W-1:0]       wall_total;
  logic [ACC_W-1:0]       sampled_self;
  logic [ACC_W-1:0]       user_total;
  logic [ACC_W-1:0]       sys_total;
  logic [ACC_W-1:0]       wait_total;
  logic                   is_running;
  logic [ACC_W-1:0]       pair_calls;
  logic [DEPTH_OUT_W-1:0] depth_now;

  modport source (output valid, status, assigned_id, calls, wall_total, sampled_self,
                  user_total, sys_total, wait_total, is_running, pair_calls, depth_now,
                  input ready);
  modport sink (input valid, status, assigned_id, calls, wall_total, sampled_self,
                user_total, sys_total, wait_total, is_running, pair_calls, depth_now,
                output ready);
endinterface
`default_nettype wire

>>> sv/cpt_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cpt_ram: generic single-write, single-read synchronous RAM
// One write port, one read port with registered data and read enable.
// ----------------------------------------------------------------------------
module cpt_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

>>> sv/cpt_entry_store.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cpt_entry_store: per-function statistics memory
// Entry RAM with one written bit per entry; an unwritten entry reads as zero.
// ----------------------------------------------------------------------------
module cpt_entry_store
  import cpt_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              we,
  input  wire logic [ENT_AW-1:0] waddr,
  input  wire entry_t            wdata,
  input  wire logic              re,
  input  wire logic [ENT_AW-1:0] raddr,
  output entry_t                 rdata
);

  logic [NUM_ENTRIES-1:0] written;
  logic                   rd_written;
  logic [ENTRY_W-1:0]     ram_rdata;

  cpt_ram #(.DEPTH(NUM_ENTRIES), .WIDTH(ENTRY_W)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      written    <= '0;
      rd_written <= 1'b0;
    end else begin
      if (we) begin
        written[waddr] <= 1'b1;
      end
      if (re) begin
        rd_written <= written[raddr];
      end
    end
  end

  // Hide stale contents of entries not touched since reset.
  assign rdata = rd_written ? entry_t'(ram_rdata) : '0;

endmodule
`default_nettype wire

>>> sv/call_profile_tracker_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// call_profile_tracker_unit: function call profiler driven by trace events
// Sequences register/enter/leave/tick/read events over entry, caller-pair
// and call-stack memories.
// ----------------------------------------------------------------------------
// Each accepted event reads the call-stack top at its transfer edge. It then
// passes through these steps to its result: S_STK reads the entry and
// caller-pair memories, S_RD forms the timestamp deltas, and S_WR updates the
// memories and loads the result register. Each memory is a synchronous RAM
// with one write port and one read port (registered read data), and the
// read-modify-write through them sets these steps. The next event is taken as
// soon as the block is back in idle, even while the last result waits to be
// transferred. An event that reaches its update step while a result is still
// waiting holds there until that result is transferred. After reset the block
// sweeps the caller-pair memory to zero, one entry per cycle (NUM_ENTRIES *
// NUM_ENTRIES = 4096 entries), and accepts no event until the sweep is done;
// sampling_enable writes are taken at any time. Statistics accumulate modulo
// 2^64; deltas are signed 49-bit differences, and only wait time is clamped
// at zero.
// ----------------------------------------------------------------------------
module call_profile_tracker_unit
  import cpt_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic cfg_we,
  input  wire logic cfg_wdata,
  cpt_evt_if.sink   evt,
  cpt_res_if.source res
);

  // Signed timestamp difference, sign extended to accumulator width.
  function automatic logic [ACC_W-1:0] sdiff(input logic [TS_W-1:0] a,
                                             input logic [TS_W-1:0] b);
    logic [TS_W:0] d;
    d = {1'b0, a} - {1'b0, b};
    return {{(ACC_W-TS_W-1){d[TS_W]}}, d};
  endfunction

  state_t state, state_next;

  // Configuration and scalar state.
  logic                sampling_enable;
  logic [USED_W-1:0]   entries_used;
  logic [DEPTH_W-1:0]  stack_depth;
  logic [TS_W-1:0]     last_tick;
  logic                tick_seen;
  logic [PAIR_AW-1:0]  clr_addr;

  // Captured event.
  logic [2:0]      cmd_q;
  logic [ID_W-1:0] id_q;
  logic [ID_W-1:0] caller_q;
  logic [TS_W-1:0] now_w_q;
  logic [TS_W-1:0] now_u_q;
  logic [TS_W-1:0] now_s_q;

  // Working registers.
  logic [ENT_AW-1:0]  ent_addr;
  logic [PAIR_AW-1:0] pair_addr;
  entry_t             ent_q;
  logic [ACC_W-1:0]   pair_q;
  logic [ACC_W-1:0]   dw, du, ds, dt;

  // Memory ports.
  entry_t             ent_rdata;
  logic               ent_re, ent_we;
  entry_t             ent_wdata;
  logic [ACC_W-1:0]   pair_rdata;
  logic               pair_re, pair_we;
  logic [PAIR_AW-1:0] pair_waddr;
  logic [ACC_W-1:0]   pair_wdata;
  logic [ID_W-1:0]    stk_rdata;
  logic               stk_re, stk_we;

  // Write-back values.
  logic [ACC_W-1:0]   uds, wt;
  logic               id_valid, has_top;
  logic [ENT_AW-1:0]  top_idx;
  logic               accept, res_free, res_load;

  logic [USED_W-1:0]  entries_used_next;
  logic [DEPTH_W-1:0] stack_depth_next;
  logic [TS_W-1:0]    last_tick_next;
  logic               tick_seen_next;

  // Result register.
  logic                   res_valid;
  status_t                status_r, status_next;
  logic [ID_W-1:0]        assigned_r, assigned_next;
  entry_t                 res_ent, res_ent_next;
  logic [ACC_W-1:0]       res_pair, res_pair_next;

  assign accept   = evt.valid && evt.ready;
  assign res_free = !res_valid || res.ready;
  assign evt.ready = (state == S_IDLE);
  assign has_top  = (stack_depth != '0);
  assign top_idx  = ENT_AW'(stk_rdata);
  assign id_valid = (USED_W'(id_q) < entries_used) && ({1'b0, id_q} < (ID_W+1)'(NUM_ENTRIES));

  cpt_entry_store u_entries (
    .clk   (clk),
    .rst   (rst),
    .we    (ent_we),
    .waddr (ent_addr),
    .wdata (ent_wdata),
    .re    (ent_re),
    .raddr (cmd_t'(cmd_q) == CMD_TICK ? top_idx : ENT_AW'(id_q)),
    .rdata (ent_rdata)
  );

  cpt_ram #(.DEPTH(PAIR_DEPTH), .WIDTH(ACC_W)) u_pairs (
    .clk   (clk),
    .we    (pair_we),
    .waddr (pair_waddr),
    .wdata (pair_wdata),
    .re    (pair_re),
    .raddr (pair_addr),
    .rdata (pair_rdata)
  );

  cpt_ram #(.DEPTH(STACK_SLOTS), .WIDTH(ID_W)) u_stack (
    .clk   (clk),
    .we    (stk_we),
    .waddr (STK_AW'(stack_depth)),
    .wdata (id_q),
    .re    (stk_re),
    .raddr (STK_AW'(stack_depth - DEPTH_W'(1))),
    .rdata (stk_rdata)
  );

  // Pair address: caller row times table size plus callee column.
  always_comb begin
    if (cmd_t'(cmd_q) == CMD_ENTER) begin
      pair_addr = PAIR_AW'(PAIR_AW'(stk_rdata) * PAIR_AW'(NUM_ENTRIES) + PAIR_AW'(id_q));
    end else begin
      pair_addr = PAIR_AW'(PAIR_AW'(caller_q) * PAIR_AW'(NUM_ENTRIES) + PAIR_AW'(id_q));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_CLR;
      sampling_enable <= 1'b0;
      entries_used    <= '0;
      stack_depth     <= '0;
      last_tick       <= '0;
      tick_seen       <= 1'b0;
      clr_addr        <= '0;
      res_valid       <= 1'b0;
    end else begin
      state        <= state_next;
      entries_used <= entries_used_next;
      stack_depth  <= stack_depth_next;
      last_tick    <= last_tick_next;
      tick_seen    <= tick_seen_next;
      if (cfg_we) begin
        sampling_enable <= cfg_wdata;
      end
      if (state == S_CLR) begin
        clr_addr <= clr_addr + PAIR_AW'(1);
      end
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (res.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  // Datapath registers: capture on transfer, snapshot reads, form deltas.
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q    <= evt.cmd;
      id_q     <= evt.func_id;
      caller_q <= evt.caller_sel;
      now_w_q  <= evt.now_wall_us;
      now_u_q  <= evt.now_user_us;
      now_s_q  <= evt.now_sys_us;
    end
    if (state == S_STK) begin
      case (cmd_t'(cmd_q))
        CMD_TICK:     ent_addr <= top_idx;
        CMD_REGISTER: ent_addr <= ENT_AW'(entries_used);
        default:      ent_addr <= ENT_AW'(id_q);
      endcase
    end
    if (state == S_RD) begin
      ent_q  <= ent_rdata;
      pair_q <= pair_rdata;
      dw     <= sdiff(now_w_q, ent_rdata.start_wall);
      du     <= sdiff(now_u_q, ent_rdata.start_user);
      ds     <= sdiff(now_s_q, ent_rdata.start_sys);
      dt     <= sdiff(now_w_q, last_tick);
    end
    if (res_load) begin
      status_r    <= status_next;
      assigned_r  <= assigned_next;
      res_ent     <= res_ent_next;
      res_pair    <= res_pair_next;
      res.depth_now <= DEPTH_OUT_W'(stack_depth_next);
    end
  end

  // Sequencer and write-back.
  always_comb begin
    state_next        = state;
    entries_used_next = entries_used;
    stack_depth_next  = stack_depth;
    last_tick_next    = last_tick;
    tick_seen_next    = tick_seen;
    stk_re    = 1'b0;
    stk_we    = 1'b0;
    ent_re    = 1'b0;
    ent_we    = 1'b0;
    ent_wdata = ent_q;
    pair_re   = 1'b0;
    pair_we   = 1'b0;
    pair_waddr = pair_addr;
    pair_wdata = pair_q + ACC_W'(1);
    res_load  = 1'b0;
    status_next   = ST_OK;
    assigned_next = '0;
    res_ent_next  = '0;
    res_pair_next = '0;
    uds = du + ds;
    wt  = dw - uds;

    case (state)
      S_CLR: begin
        // Zero the pair memory one entry per cycle.
        pair_we    = 1'b1;
        pair_waddr = clr_addr;
        pair_wdata = '0;
        if (clr_addr == PAIR_AW'(PAIR_DEPTH - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          stk_re     = 1'b1;
          state_next = S_STK;
        end
      end
      S_STK: begin
        ent_re     = 1'b1;
        pair_re    = 1'b1;
        state_next = S_RD;
      end
      S_RD: begin
        state_next = S_WR;
      end
      S_WR: begin
        if (res_free) begin
          res_load   = 1'b1;
          state_next = S_IDLE;
          case (cmd_t'(cmd_q))
            CMD_REGISTER: begin
              if (entries_used == USED_W'(NUM_ENTRIES)) begin
                status_next = ST_FULL;
              end else begin
                ent_we            = 1'b1;
                ent_wdata         = '0;
                assigned_next     = ID_W'(entries_used);
                entries_used_next = entries_used + USED_W'(1);
              end
            end
            CMD_ENTER: begin
              if (!id_valid) begin
                status_next = ST_INVALID;
              end else begin
                ent_we               = 1'b1;
                ent_wdata.calls      = ent_q.calls + ACC_W'(1);
                ent_wdata.active     = 1'b1;
                ent_wdata.start_wall = now_w_q;
                ent_wdata.start_user = now_u_q;
                ent_wdata.start_sys  = now_s_q;
                // Count the caller pair from the current stack top.
                pair_we = has_top;
                if (stack_depth < DEPTH_W'(STACK_SLOTS)) begin
                  stk_we           = 1'b1;
                  stack_depth_next = stack_depth + DEPTH_W'(1);
                end
              end
            end
            CMD_LEAVE: begin
              if (!id_valid) begin
                status_next = ST_INVALID;
              end else begin
                ent_we           = 1'b1;
                ent_wdata.wall   = ent_q.wall + dw;
                ent_wdata.user   = ent_q.user + du;
                ent_wdata.sys    = ent_q.sys + ds;
                ent_wdata.wait_t = ent_q.wait_t + (wt[ACC_W-1] ? '0 : wt);
                ent_wdata.active = 1'b0;
                if (has_top && stk_rdata == id_q) begin
                  stack_depth_next = stack_depth - DEPTH_W'(1);
                end
              end
            end
            CMD_TICK: begin
              if (sampling_enable) begin
                if (!tick_seen) begin
                  tick_seen_next = 1'b1;
                end else if (has_top) begin
                  ent_we           = 1'b1;
                  ent_wdata.self_t = ent_q.self_t + dt;
                end
                last_tick_next = now_w_q;
              end
            end
            CMD_READ: begin
              if (!id_valid) begin
                status_next = ST_INVALID;
              end else begin
                res_ent_next  = ent_q;
                res_pair_next = pair_q;
              end
            end
            default: begin
              status_next = ST_INVALID;
            end
          endcase
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign res.valid        = res_valid;
  assign res.status       = status_r;
  assign res.assigned_id  = assigned_r;
  assign res.calls        = res_ent.calls;
  assign res.wall_total   = res_ent.wall;
  assign res.sampled_self = res_ent.self_t;
  assign res.user_total   = res_ent.user;
  assign res.sys_total    = res_ent.sys;
  assign res.wait_total   = res_ent.wait_t;
  assign res.is_running   = res_ent.active;
  assign res.pair_calls   = res_pair;

endmodule
`default_nettype wire

>>> sv/cpt_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cpt_checker: port-level assertions for the call profile tracker
// Watches the event and result channels of the top level.
// ----------------------------------------------------------------------------
module cpt_checker
  import cpt_pkg::*;
(
  input wire logic                   clk,
  input wire logic                   rst,
  input wire logic                   evt_valid,
  input wire logic                   evt_ready,
  input wire logic                   res_valid,
  input wire logic                   res_ready,
  input wire logic [1:0]             res_status,
  input wire logic [ACC_W-1:0]       res_calls,
  input wire logic [ACC_W-1:0]       res_pair_calls,
  input wire logic [DEPTH_OUT_W-1:0] res_depth_now
);

  // No result may appear in the cycle after reset.
  a_reset_quiet: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid right after reset");

  // A stalled result holds.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_status) && $stable(res_calls))
    else $error("stalled result changed");

  // Rejected events report no statistics.
  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_status != ST_OK |-> res_calls == '0 && res_pair_calls == '0)
    else $error("statistics on a rejected event");

  // Stack depth never exceeds its slots, and the status is a defined code.
  a_depth: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> res_depth_now <= DEPTH_OUT_W'(STACK_SLOTS) && res_status <= ST_FULL)
    else $error("bad depth or status");

  // One event in flight: no transfer the cycle after another.
  a_seq: assert property (@(posedge clk) disable iff (rst)
    evt_valid && evt_ready |=> !evt_ready)
    else $error("back-to-back event transfer");

endmodule

bind call_profile_tracker_unit cpt_checker u_cpt_checker (
  .clk            (clk),
  .rst            (rst),
  .evt_valid      (evt.valid),
  .evt_ready      (evt.ready),
  .res_valid      (res.valid),
  .res_ready      (res.ready),
  .res_status     (res.status),
  .res_calls      (res.calls),
  .res_pair_calls (res.pair_calls),
  .res_depth_now  (res.depth_now)
);
`default_nettype wire
